FILE: hw/rtl/twfq_pkg.sv
// ----------------------------------------------------------------------------
// twfq_pkg: shared types and codes of the frame queue
// Cell control word, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package twfq_pkg;

    // operation codes of an input item
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // configuration register indexes
    localparam logic REG_SPAN_CAP  = 1'b0;
    localparam logic REG_HIGH_WM   = 1'b1;

    // configuration register width and reset values
    localparam int unsigned CFG_BITS = 32;
    localparam logic [CFG_BITS-1:0] SPAN_CAP_RESET = 32'd500000;
    localparam logic [CFG_BITS-1:0] HIGH_WM_RESET  = 32'd300000;

    // per-cell control: take the neighbor's entry, or load a new one
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/time_window_frame_queue.sv
// ----------------------------------------------------------------------------
// time_window_frame_queue: timestamp-windowed frame queue with nearest match
// Ring of entry cells, oldest in cell 0, with a push/trim/scan sequencer.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, func, stamp, tag_in) takes
// one item at a time; func selects push or query. Each item gives exactly one
// result item on the output channel (out_valid, out_stall, tag_out, tag_valid,
// held_count, pause_producer, full_drop), held in an output register.
// Steps: a push is accepted, then loaded (ST_PUSH), then trimmed one dropped
// entry at a time up to a final check (ST_TRIM); then its result is registered
// (ST_DONE). A query walks the whole ring of QUEUE_DEPTH cells past the
// compare unit at cell 0, one cell per cycle (ST_SCAN); a query on an empty
// queue goes straight to ST_DONE. in_stall is high while an item is in work;
// a new item may be taken while a finished result still waits in the output
// register. When the receiver stalls, the result holds and a following item
// waits at its end. Configuration (cfg_write, cfg_index, cfg_data) is for the
// user to write while idle; the block itself does not enforce it. Reset empties
// the queue, forgets the last tag and restores the register defaults; cell
// contents are not cleared, they are never read unheld.
// ----------------------------------------------------------------------------
module time_window_frame_queue
    import twfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_BITS  = 32,
    parameter int TAG_BITS    = 16,
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [STAMP_BITS-1:0] stamp,
    input  logic [TAG_BITS-1:0]   tag_in,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TAG_BITS-1:0]   tag_out,
    output logic                  tag_valid,
    output logic [COUNT_BITS-1:0] held_count,
    output logic                  pause_producer,
    output logic                  full_drop
);

    localparam int CMP_BITS = (STAMP_BITS > CFG_BITS) ? STAMP_BITS : CFG_BITS;
    localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(QUEUE_DEPTH);
    localparam logic [COUNT_BITS-1:0] LAST_C  = COUNT_BITS'(QUEUE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_TRIM = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CFG_BITS-1:0]   span_cap_reg, high_wm_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] walk_reg, walk_next;
    logic [TAG_BITS-1:0]   last_tag_reg, last_tag_next;
    logic                  last_valid_reg, last_valid_next;
    logic [STAMP_BITS-1:0] newest_reg, newest_next;
    logic [STAMP_BITS-1:0] item_stamp_reg, item_stamp_next;
    logic [TAG_BITS-1:0]   item_tag_reg, item_tag_next;
    logic [STAMP_BITS-1:0] best_dist_reg, best_dist_next;
    logic [TAG_BITS-1:0]   res_tag_reg, res_tag_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_drop_reg, res_drop_next;

    logic                  out_valid_reg, out_valid_next;
    logic [TAG_BITS-1:0]   out_tag_reg, out_tag_next;
    logic                  out_tag_valid_reg, out_tag_valid_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                  out_pause_reg, out_pause_next;
    logic                  out_drop_reg, out_drop_next;

    cell_ctrl_t            cell_ctrl [QUEUE_DEPTH];
    logic [STAMP_BITS-1:0] cell_stamp [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   cell_tag [QUEUE_DEPTH];

    logic                  in_accept;
    logic                  out_free;
    logic                  queue_full;
    logic                  shift_all;
    logic                  load_last;
    logic [COUNT_BITS-1:0] load_slot;
    logic                  load_any;
    logic                  newest_ge_oldest;
    logic [CMP_BITS-1:0]   span_wide;
    logic                  span_over_cap;
    logic [STAMP_BITS-1:0] gap_abs;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign queue_full = (count_reg == DEPTH_C);

    // held span against the oldest entry in cell 0
    assign newest_ge_oldest = (newest_reg >= cell_stamp[0]);
    assign span_wide     = CMP_BITS'(newest_reg - cell_stamp[0]);
    assign span_over_cap = newest_ge_oldest && (span_wide > CMP_BITS'(span_cap_reg));

    // absolute distance of the entry at cell 0 from the wanted time
    assign gap_abs = (cell_stamp[0] > item_stamp_reg) ? (cell_stamp[0] - item_stamp_reg)
                                                      : (item_stamp_reg - cell_stamp[0]);

    // chain controls: whole-ring rotation, or a load at one cell
    always_comb
    begin
        shift_all = 1'b0;
        load_last = 1'b0;
        load_any  = 1'b0;
        load_slot = count_reg;
        case (state_reg)
            ST_PUSH:
            begin
                load_any = 1'b1;
                if (queue_full)
                begin
                    shift_all = 1'b1;
                    load_last = 1'b1;
                    load_slot = LAST_C;
                end
            end
            ST_TRIM: shift_all = span_over_cap;
            ST_SCAN: shift_all = 1'b1;
            default: shift_all = 1'b0;
        endcase
    end

    // cell chain, each cell takes its upper neighbor, the last wraps to cell 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam int NB = (i + 1) % QUEUE_DEPTH;

        always_comb
        begin
            cell_ctrl[i].shift = shift_all;
            cell_ctrl[i].load  = load_any && (load_slot == COUNT_BITS'(i));
        end

        twfq_cell #(
            .STAMP_BITS (STAMP_BITS),
            .TAG_BITS   (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .load_stamp (item_stamp_reg),
            .load_tag   (item_tag_reg),
            .next_stamp (cell_stamp[NB]),
            .next_tag   (cell_tag[NB]),
            .stamp      (cell_stamp[i]),
            .tag        (cell_tag[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        last_tag_next   = last_tag_reg;
        last_valid_next = last_valid_reg;
        newest_next     = newest_reg;
        item_stamp_next = item_stamp_reg;
        item_tag_next   = item_tag_reg;
        best_dist_next  = best_dist_reg;
        res_tag_next    = res_tag_reg;
        res_valid_next  = res_valid_reg;
        res_drop_next   = res_drop_reg;

        out_valid_next     = out_valid_reg && out_stall;
        out_tag_next       = out_tag_reg;
        out_tag_valid_next = out_tag_valid_reg;
        out_count_next     = out_count_reg;
        out_pause_next     = out_pause_reg;
        out_drop_next      = out_drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_stamp_next = stamp;
                    item_tag_next   = tag_in;
                    res_tag_next    = '0;
                    res_valid_next  = 1'b0;
                    res_drop_next   = 1'b0;
                    walk_next       = '0;
                    if (func == FUNC_PUSH)
                        state_next = ST_PUSH;
                    else if (count_reg == '0)
                    begin
                        // empty queue answers with the last pushed tag
                        res_tag_next   = last_tag_reg;
                        res_valid_next = last_valid_reg;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!queue_full)
                    count_next = count_reg + 1'b1;
                res_drop_next   = queue_full;
                newest_next     = item_stamp_reg;
                last_tag_next   = item_tag_reg;
                last_valid_next = 1'b1;
                state_next      = ST_TRIM;
            end
            ST_TRIM:
            begin
                if (span_over_cap)
                    count_next = count_reg - 1'b1;
                else
                    state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // earliest entry wins ties: strict less-than
                if ((walk_reg < count_reg) && ((walk_reg == '0) || (gap_abs < best_dist_reg)))
                begin
                    best_dist_next = gap_abs;
                    res_tag_next   = cell_tag[0];
                end
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_C)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_tag_next       = res_tag_reg;
                    out_tag_valid_next = res_valid_reg;
                    out_count_next     = count_reg;
                    out_pause_next     = (count_reg != '0) && newest_ge_oldest &&
                                         (span_wide >= CMP_BITS'(high_wm_reg));
                    out_drop_next      = res_drop_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            walk_reg       <= '0;
            last_tag_reg   <= '0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            span_cap_reg   <= SPAN_CAP_RESET;
            high_wm_reg    <= HIGH_WM_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            walk_reg       <= walk_next;
            last_tag_reg   <= last_tag_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write && (cfg_index == REG_SPAN_CAP))
                span_cap_reg <= cfg_data;
            if (cfg_write && (cfg_index == REG_HIGH_WM))
                high_wm_reg <= cfg_data;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        newest_reg        <= newest_next;
        item_stamp_reg    <= item_stamp_next;
        item_tag_reg      <= item_tag_next;
        best_dist_reg     <= best_dist_next;
        res_tag_reg       <= res_tag_next;
        res_valid_reg     <= res_valid_next;
        res_drop_reg      <= res_drop_next;
        out_tag_reg       <= out_tag_next;
        out_tag_valid_reg <= out_tag_valid_next;
        out_count_reg     <= out_count_next;
        out_pause_reg     <= out_pause_next;
        out_drop_reg      <= out_drop_next;
    end

    assign out_valid      = out_valid_reg;
    assign tag_out        = out_tag_reg;
    assign tag_valid      = out_tag_valid_reg;
    assign held_count     = out_count_reg;
    assign pause_producer = out_pause_reg;
    assign full_drop      = out_drop_reg;

endmodule

FILE: hw/rtl/twfq_cell.sv
// ----------------------------------------------------------------------------
// twfq_cell: one storage cell of the frame queue chain
// Holds one (timestamp, tag) entry; loads a new entry or takes its neighbor's.
// ----------------------------------------------------------------------------
module twfq_cell
    import twfq_pkg::*;
#(
    parameter int STAMP_BITS = 32,
    parameter int TAG_BITS   = 16
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [STAMP_BITS-1:0] load_stamp,
    input  logic [TAG_BITS-1:0]   load_tag,
    input  logic [STAMP_BITS-1:0] next_stamp,
    input  logic [TAG_BITS-1:0]   next_tag,
    output logic [STAMP_BITS-1:0] stamp,
    output logic [TAG_BITS-1:0]   tag
);

    logic [STAMP_BITS-1:0] stamp_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [STAMP_BITS-1:0] stamp_next;
    logic [TAG_BITS-1:0]   tag_next;

    // load has priority over the shift from the neighbor
    always_comb
    begin
        stamp_next = stamp_reg;
        tag_next   = tag_reg;
        if (ctrl.load)
        begin
            stamp_next = load_stamp;
            tag_next   = load_tag;
        end
        else if (ctrl.shift)
        begin
            stamp_next = next_stamp;
            tag_next   = next_tag;
        end
    end

    // entry payload, no reset needed
    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        tag_reg   <= tag_next;
    end

    assign stamp = stamp_reg;
    assign tag   = tag_reg;

endmodule
